>>> src/scs_pkg.sv
// scs_pkg: shared types and constants for the sweep capture scope
// no dependencies; imported by every module of the block

package scs_pkg;

    // geometry of the capture buffer and the display
    localparam int BUFFER_WIDTH   = 128;
    localparam int DISPLAY_HEIGHT = 64;

    // field widths
    localparam int CMD_W     = 2;
    localparam int SAMPLE_W  = 12;
    localparam int COL_W     = 7;
    localparam int ROW_W     = 6;
    localparam int WINDOW_W  = 17;
    localparam int TICK_W    = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = WINDOW_W;

    // full scale of the converter
    localparam int SAMPLE_MAX = (2 ** SAMPLE_W) - 1;
    localparam int ROW_TOP    = DISPLAY_HEIGHT - 1;
    localparam int TOP_W      = $clog2(DISPLAY_HEIGHT);
    localparam int PROD_W     = SAMPLE_W + TOP_W;
    localparam int QUOT_W     = PROD_W - SAMPLE_W + 1;

    // timing state
    localparam int ELAPSED_W   = 24;
    localparam int SLOT_W      = 32;
    localparam int ADDR_W      = $clog2(BUFFER_WIDTH);
    localparam int IDX_W       = ADDR_W + 1;
    localparam int SCALE_SHIFT = $clog2(BUFFER_WIDTH);
    localparam int CMP_W       = (ELAPSED_W + SCALE_SHIFT > SLOT_W) ?
                                 (ELAPSED_W + SCALE_SHIFT) : SLOT_W;

    // register reset values
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10000);
    localparam logic [TICK_W-1:0]   TICK_RESET   = TICK_W'(10);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_REARM = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_READ
    } state_t;

    // request from the controller to the sample store
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
    } mem_req_t;

endpackage

>>> src/sweep_capture_scope.sv
// sweep_capture_scope: top level of the untriggered scope capture buffer
// depends on scs_pkg, scs_ctrl, scs_store, scs_row; holds the config registers
//
// channel   signals                          direction  beat taken when
// command   start busy command sample column  in        start && !busy
// result    done pixel_row frame_ready        out       done (one cycle)
// config    cfg_valid cfg_ready cfg_index     in        cfg_valid && cfg_ready
//           cfg_data
//
// tick while capturing: the fill loop makes one memory write per cycle, up to the
// buffer width, then the result shows; read: the result passes the memory read,
// multiply and divide stages; rearm, dropped tick, other: answered from idle.
// busy falls in the cycle the result shows, so the next beat can follow it.
// reset: capture armed, store reads as zero, window 10000 us, tick 10 us.
// the result side cannot stall; cfg_ready is always high.

module sweep_capture_scope (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [scs_pkg::CMD_W-1:0]       command,
    input  logic [scs_pkg::SAMPLE_W-1:0]    sample,
    input  logic [scs_pkg::COL_W-1:0]       column,
    output logic                            done,
    output logic [scs_pkg::ROW_W-1:0]       pixel_row,
    output logic                            frame_ready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [scs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import scs_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    logic [TICK_W-1:0]   tick_reg;

    mem_req_t            mem_req;
    logic                rd_valid;
    logic [SAMPLE_W-1:0] rd_data;
    logic                row_valid;
    logic [ROW_W-1:0]    row_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            tick_reg   <= TICK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WINDOW: window_reg <= cfg_data[WINDOW_W-1:0];
                CFG_TICK:   tick_reg   <= cfg_data[TICK_W-1:0];
                default:    window_reg <= window_reg;
            endcase
        end
    end

    scs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .sample      (sample),
        .column      (column),
        .window_len  (window_reg),
        .tick_us     (tick_reg),
        .row_valid   (row_valid),
        .row_data    (row_data),
        .mem_req     (mem_req),
        .busy        (busy),
        .done        (done),
        .pixel_row   (pixel_row),
        .frame_ready (frame_ready)
    );

    scs_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .mem_req  (mem_req),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    scs_row u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid),
        .in_sample (rd_data),
        .row_valid (row_valid),
        .row_data  (row_data)
    );

endmodule

>>> src/scs_store.sv
// scs_store: sample memory with one write and one registered read port
// depends on scs_pkg; per-entry valid bits make unwritten entries read as zero

module scs_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  scs_pkg::mem_req_t             mem_req,
    output logic                          rd_valid,
    output logic [scs_pkg::SAMPLE_W-1:0]  rd_data
);
    import scs_pkg::*;

    logic [SAMPLE_W-1:0]     mem [BUFFER_WIDTH];
    logic [SAMPLE_W-1:0]     rdata_reg;
    logic [BUFFER_WIDTH-1:0] written_reg;
    logic                    hit_reg;
    logic                    rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.wr_en)
        begin
            mem[mem_req.wr_addr] <= mem_req.wr_data;
        end
        if (mem_req.rd_en)
        begin
            rdata_reg <= mem[mem_req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_req.wr_en)
            begin
                written_reg[mem_req.wr_addr] <= 1'b1;
            end
            if (mem_req.rd_en)
            begin
                hit_reg <= written_reg[mem_req.rd_addr];
            end
            rvalid_reg <= mem_req.rd_en;
        end
    end

    // entries never written since reset hold zero
    assign rd_data  = hit_reg ? rdata_reg : '0;
    assign rd_valid = rvalid_reg;

endmodule

>>> src/scs_row.sv
// scs_row: two-stage conversion of a stored sample into a display row
// depends on scs_pkg; row = top - sample*top/SAMPLE_MAX, clamped at zero

module scs_row (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [scs_pkg::SAMPLE_W-1:0]  in_sample,
    output logic                          row_valid,
    output logic [scs_pkg::ROW_W-1:0]     row_data
);
    import scs_pkg::*;

    logic [PROD_W-1:0]   prod_reg;
    logic                prod_valid_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                row_valid_reg;

    logic [QUOT_W-1:0]   quot_est;
    logic [SAMPLE_W:0]   rem_est;
    logic [QUOT_W-1:0]   quot;
    logic [ROW_W-1:0]    row_next;

    // divide by 2^n-1: estimate by shift, remainder is low bits plus estimate,
    // at most one correction step
    always_comb
    begin
        quot_est = QUOT_W'(prod_reg >> SAMPLE_W);
        rem_est  = (SAMPLE_W+1)'(prod_reg[SAMPLE_W-1:0]) + (SAMPLE_W+1)'(quot_est);
        quot     = (rem_est >= (SAMPLE_W+1)'(SAMPLE_MAX)) ? quot_est + 1'b1 : quot_est;
        if (quot > QUOT_W'(ROW_TOP))
        begin
            row_next = '0;
        end
        else
        begin
            row_next = ROW_W'(QUOT_W'(ROW_TOP) - quot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= PROD_W'(in_sample) * PROD_W'(ROW_TOP);
        end
        if (prod_valid_reg)
        begin
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            row_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            row_valid_reg  <= prod_valid_reg;
        end
    end

    assign row_valid = row_valid_reg;
    assign row_data  = row_reg;

endmodule

>>> src/scs_ctrl.sv
// scs_ctrl: command sequencer, sweep timing and slot fill loop
// depends on scs_pkg; drives the store request, takes rows from scs_row

module scs_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [scs_pkg::CMD_W-1:0]     command,
    input  logic [scs_pkg::SAMPLE_W-1:0]  sample,
    input  logic [scs_pkg::COL_W-1:0]     column,
    input  logic [scs_pkg::WINDOW_W-1:0]  window_len,
    input  logic [scs_pkg::TICK_W-1:0]    tick_us,
    input  logic                          row_valid,
    input  logic [scs_pkg::ROW_W-1:0]     row_data,
    output scs_pkg::mem_req_t             mem_req,
    output logic                          busy,
    output logic                          done,
    output logic [scs_pkg::ROW_W-1:0]     pixel_row,
    output logic                          frame_ready
);
    import scs_pkg::*;

    state_t                state_reg, state_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  capturing_reg, capturing_next;
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic                  done_reg, done_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  frame_reg, frame_next;

    logic [CMP_W-1:0]      scaled_time;
    logic                  slot_due;
    logic                  col_in_range;

    // elapsed time scaled by the buffer width against the scaled slot time
    assign scaled_time  = CMP_W'(elapsed_reg) << SCALE_SHIFT;
    assign slot_due     = (idx_reg < IDX_W'(BUFFER_WIDTH))
                          && (scaled_time > CMP_W'(slot_reg));
    assign col_in_range = 32'(column) < 32'(BUFFER_WIDTH);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (command == CMD_TICK) && capturing_reg)
                begin
                    state_next = ST_FILL;
                end
                else if (start && (command == CMD_READ) && col_in_range)
                begin
                    state_next = ST_READ;
                end
            end
            ST_FILL:
            begin
                if (!slot_due)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (row_valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        elapsed_next   = elapsed_reg;
        slot_next      = slot_reg;
        idx_next       = idx_reg;
        capturing_next = capturing_reg;
        sample_next    = sample_reg;
        done_next      = 1'b0;
        row_next       = row_reg;
        frame_next     = frame_reg;
        mem_req        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        CMD_TICK:
                        begin
                            if (capturing_reg)
                            begin
                                elapsed_next = elapsed_reg + ELAPSED_W'(tick_us);
                                sample_next  = sample;
                            end
                            else
                            begin
                                // stopped: tick is dropped
                                done_next  = 1'b1;
                                row_next   = '0;
                                frame_next = 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (col_in_range)
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = ADDR_W'(column);
                            end
                            else
                            begin
                                done_next  = 1'b1;
                                row_next   = '0;
                                frame_next = !capturing_reg;
                            end
                        end
                        CMD_REARM:
                        begin
                            elapsed_next   = '0;
                            slot_next      = '0;
                            idx_next       = '0;
                            capturing_next = 1'b1;
                            done_next      = 1'b1;
                            row_next       = '0;
                            frame_next     = 1'b0;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            row_next   = '0;
                            frame_next = !capturing_reg;
                        end
                    endcase
                end
            end
            ST_FILL:
            begin
                if (slot_due)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = idx_reg[ADDR_W-1:0];
                    mem_req.wr_data = sample_reg;
                    slot_next       = slot_reg + SLOT_W'(window_len);
                    idx_next        = idx_reg + 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    row_next   = '0;
                    frame_next = 1'b0;
                    if (idx_reg >= IDX_W'(BUFFER_WIDTH))
                    begin
                        // frame complete
                        elapsed_next   = '0;
                        slot_next      = '0;
                        idx_next       = '0;
                        capturing_next = 1'b0;
                        frame_next     = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (row_valid)
                begin
                    done_next  = 1'b1;
                    row_next   = row_data;
                    frame_next = !capturing_reg;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            elapsed_reg   <= '0;
            slot_reg      <= '0;
            idx_reg       <= '0;
            capturing_reg <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            slot_reg      <= slot_next;
            idx_reg       <= idx_next;
            capturing_reg <= capturing_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        row_reg    <= row_next;
        frame_reg  <= frame_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign pixel_row   = row_reg;
    assign frame_ready = frame_reg;

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= IDX_W'(BUFFER_WIDTH))
        else $error("write index beyond buffer");

    a_write_only_filling: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en |-> (capturing_reg && (state_reg == ST_FILL)))
        else $error("store written outside the fill loop");

    a_stopped_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !capturing_reg |-> ((idx_reg == '0) && (elapsed_reg == '0) && (slot_reg == '0)))
        else $error("sweep state not cleared while stopped");

    a_row_in_read: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid |-> (state_reg == ST_READ))
        else $error("row arrived outside a read");

    a_done_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FILL) && !slot_due) |=> (done_reg && (state_reg == ST_IDLE)))
        else $error("fill loop ended without a result");

endmodule
